/* sv/code_line_table_decoder_macros.svh */
// assertion macros shared by the line table decoder rtl
`ifndef CODE_LINE_TABLE_DECODER_MACROS_SVH
`define CODE_LINE_TABLE_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CLTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cltd_pkg.sv */
// shared types and codes of the line table decoder
`default_nettype none

package cltd_pkg;

  // table layouts selected by the format register
  localparam logic [1:0] FMT_COMPACT  = 2'd0;
  localparam logic [1:0] FMT_PAIRED   = 2'd1;
  localparam logic [1:0] FMT_LEGACY   = 2'd2;
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT     = 2'd0;
  localparam logic [1:0] REG_QUERY      = 2'd1;
  localparam logic [1:0] REG_FIRST_LINE = 2'd2;

  localparam logic [30:0] FIRST_LINE_RESET = 31'd1;

  typedef enum logic [3:0] {
    PH_START        = 4'd0,
    PH_FIRST        = 4'd1,
    PH_LONG_LINE    = 4'd2,
    PH_LONG_ENDLINE = 4'd3,
    PH_LONG_COL     = 4'd4,
    PH_LONG_ENDCOL  = 4'd5,
    PH_NOCOL_LINE   = 4'd6,
    PH_OL_COL       = 4'd7,
    PH_OL_ENDCOL    = 4'd8,
    PH_SHORT2       = 4'd9,
    PH_PAIR_SECOND  = 4'd10
  } phase_e;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] query;
    logic [30:0] first_line;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] start_ofs;
    logic [31:0] end_ofs;
    logic [3:0]  kind;
    logic [31:0] line;
    logic [31:0] end_line;
    logic [31:0] col;
    logic [31:0] end_col;
    logic [31:0] acc;
    logic [4:0]  shift;
    logic        done;
  } state_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] line_start;
    logic signed [31:0] line_end;
    logic signed [31:0] column_start;
    logic signed [31:0] column_end;
  } result_t;

endpackage

`default_nettype wire

/* sv/cltd_step.sv */
// next-state and result logic for one table byte
`default_nettype none

module cltd_step (
  input  cltd_pkg::cfg_t    cfg_i,
  input  cltd_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output cltd_pkg::state_t  state_o,
  output logic              emit_o,
  output cltd_pkg::result_t result_o
);
  import cltd_pkg::*;

  localparam logic [3:0] KIND_NONE  = 4'd15;
  localparam logic [3:0] KIND_LONG  = 4'd14;
  localparam logic [3:0] KIND_NOCOL = 4'd13;
  localparam logic [3:0] KIND_ONE   = 4'd10;
  localparam logic [4:0] SHIFT_MAX  = 5'd30;
  localparam logic [4:0] SHIFT_SAT  = 5'd31;
  localparam logic [7:0] NO_LINE    = 8'h80;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [31:0] sign8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] zigzag(input logic [31:0] v);
    logic [31:0] mag;
    mag = {1'b0, v[31:1]};
    return v[0] ? (32'd0 - mag) : mag;
  endfunction

  always_comb begin
    state_t      s;
    logic        emit;
    logic        found;
    logic        cmpl;
    logic [1:0]  fmt;
    logic [31:0] acc_n;
    logic [5:0]  shift_sum;

    s         = state_i;
    emit      = 1'b0;
    found     = 1'b1;
    cmpl      = 1'b0;
    acc_n     = 32'd0;
    shift_sum = 6'd0;
    fmt       = (cfg_i.fmt == FMT_RESERVED) ? FMT_LEGACY : cfg_i.fmt;

    if (state_i.done) begin
      // swallow the tail of an answered table
      if (last_i) begin
        s.phase = PH_START;
        s.done  = 1'b0;
      end
    end else begin
      if (s.phase == PH_START) begin
        s.line      = {1'b0, cfg_i.first_line};
        s.end_line  = 32'd0;
        s.col       = 32'd0;
        s.end_col   = 32'd0;
        s.start_ofs = 32'd0;
        s.end_ofs   = 32'd0;
        s.phase     = PH_FIRST;
      end

      unique case (fmt)
        FMT_COMPACT: begin
          if (s.phase > PH_SHORT2) begin
            s.phase = PH_FIRST;
          end
          unique case (s.phase)
            PH_FIRST: begin
              s.kind    = byte_i[6:3];
              s.end_ofs = sat_add(s.start_ofs, {29'd0, byte_i[2:0]} + 32'd1);
              s.acc     = 32'd0;
              s.shift   = 5'd0;
              if (s.kind == KIND_NONE) begin
                cmpl = 1'b1;
              end else if (s.kind == KIND_LONG) begin
                s.phase = PH_LONG_LINE;
              end else if (s.kind == KIND_NOCOL) begin
                s.phase = PH_NOCOL_LINE;
              end else if (s.kind >= KIND_ONE) begin
                s.line     = s.line + {28'd0, s.kind - KIND_ONE};
                s.end_line = s.line;
                s.phase    = PH_OL_COL;
              end else begin
                s.phase = PH_SHORT2;
              end
            end
            PH_OL_COL: begin
              s.col   = {24'd0, byte_i};
              s.phase = PH_OL_ENDCOL;
            end
            PH_OL_ENDCOL: begin
              s.end_col = {24'd0, byte_i};
              cmpl      = 1'b1;
            end
            PH_SHORT2: begin
              // bit 7 of the second byte is ignored
              s.col      = {25'd0, s.kind, byte_i[6:4]};
              s.end_col  = s.col + {28'd0, byte_i[3:0]};
              s.end_line = s.line;
              cmpl       = 1'b1;
            end
            default: begin
              // 6-bit varint digits, bits past 31 dropped
              acc_n = s.acc;
              if (s.shift <= SHIFT_MAX) begin
                acc_n = s.acc | ({26'd0, byte_i[5:0]} << s.shift);
              end
              s.acc = acc_n;
              if (byte_i[6]) begin
                shift_sum = {1'b0, s.shift} + 6'd6;
                s.shift   = (shift_sum > {1'b0, SHIFT_MAX}) ? SHIFT_SAT : shift_sum[4:0];
              end else begin
                s.acc   = 32'd0;
                s.shift = 5'd0;
                unique case (s.phase)
                  PH_LONG_LINE: begin
                    s.line  = s.line + zigzag(acc_n);
                    s.phase = PH_LONG_ENDLINE;
                  end
                  PH_LONG_ENDLINE: begin
                    s.end_line = s.line + acc_n;
                    s.phase    = PH_LONG_COL;
                  end
                  PH_LONG_COL: begin
                    s.col   = acc_n - 32'd1;
                    s.phase = PH_LONG_ENDCOL;
                  end
                  PH_LONG_ENDCOL: begin
                    s.end_col = acc_n - 32'd1;
                    cmpl      = 1'b1;
                  end
                  default: begin
                    // no-column entry
                    s.line     = s.line + zigzag(acc_n);
                    s.end_line = s.line;
                    s.col      = 32'hFFFF_FFFF;
                    s.end_col  = 32'hFFFF_FFFF;
                    cmpl       = 1'b1;
                  end
                endcase
              end
            end
          endcase
          if (cmpl) begin
            s.phase = PH_FIRST;
            if (s.start_ofs <= cfg_i.query && cfg_i.query < s.end_ofs) begin
              emit = 1'b1;
            end
            s.start_ofs = s.end_ofs;
          end
          if (!emit && last_i) begin
            emit  = 1'b1;
            found = 1'b0;
          end
        end
        FMT_PAIRED: begin
          if (s.phase != PH_PAIR_SECOND) begin
            s.start_ofs = sat_add(s.start_ofs, {24'd0, byte_i});
            s.phase     = PH_PAIR_SECOND;
          end else begin
            if (byte_i != NO_LINE) begin
              s.line = s.line + sign8(byte_i);
            end
            s.phase = PH_FIRST;
            if ({1'b0, s.start_ofs} > {cfg_i.query, 1'b0}) begin
              emit = 1'b1;
            end
          end
          if (last_i) begin
            emit = 1'b1;
          end
        end
        default: begin
          // legacy pairs: offset checked before the line delta
          if (s.phase != PH_PAIR_SECOND) begin
            s.start_ofs = sat_add(s.start_ofs, {24'd0, byte_i});
            if (s.start_ofs > cfg_i.query) begin
              emit = 1'b1;
            end else begin
              s.phase = PH_PAIR_SECOND;
            end
          end else begin
            s.line  = s.line + sign8(byte_i);
            s.phase = PH_FIRST;
          end
          if (last_i) begin
            emit = 1'b1;
          end
        end
      endcase

      if (emit) begin
        if (last_i) begin
          s.phase = PH_START;
          s.done  = 1'b0;
        end else begin
          s.done = 1'b1;
        end
      end
    end

    result_o.found = found;
    if (!found) begin
      result_o.line_start   = 32'sd0;
      result_o.line_end     = 32'sd0;
      result_o.column_start = 32'sd0;
      result_o.column_end   = 32'sd0;
    end else if (fmt == FMT_COMPACT) begin
      result_o.line_start   = s.line;
      result_o.line_end     = s.end_line;
      result_o.column_start = s.col;
      result_o.column_end   = s.end_col;
    end else begin
      result_o.line_start   = s.line;
      result_o.line_end     = s.line;
      result_o.column_start = 32'sd0;
      result_o.column_end   = 32'sd0;
    end

    state_o = s;
    emit_o  = emit;
  end

endmodule

`default_nettype wire

/* sv/code_line_table_decoder.sv */
// line table decoder: one table byte per transaction, at most one location per table
// a byte is held in the input register, then its result goes to the output register
// throughput: one byte per cycle unless the output stalls; the decode of a byte is one
//   pass of logic between the input register and the parser state / result register
// reset clears the handshake, parser phase and config (format 0, query 0, first line 1)
// a format write re-arms the parser and drops any partly read table
`default_nettype none
`include "code_line_table_decoder_macros.svh"

module code_line_table_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // table byte channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         table_byte_i,
  input  logic               table_last_i,
  // location result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic signed [31:0] line_start_o,
  output logic signed [31:0] line_end_o,
  output logic signed [31:0] column_start_o,
  output logic signed [31:0] column_end_o
);
  import cltd_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // input register holding one byte transaction
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parser state and result register
  state_t  st_q, st_d;
  logic    out_valid_q;
  result_t res_q, res_d;

  logic step_emit;
  logic go;

  // the held byte is decoded once the result register has room for a possible result
  assign go         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || go;

  cltd_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (st_d),
    .emit_o   (step_emit),
    .result_o (res_d)
  );

  // control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt        <= FMT_COMPACT;
      cfg_q.query      <= 32'd0;
      cfg_q.first_line <= FIRST_LINE_RESET;
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      st_q             <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FORMAT:     cfg_q.fmt        <= cfg_data_i[1:0];
          REG_QUERY:      cfg_q.query      <= cfg_data_i;
          REG_FIRST_LINE: cfg_q.first_line <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      // format change abandons the table in progress
      priority if (cfg_we_i && cfg_index_i == REG_FORMAT) begin
        st_q.phase <= PH_START;
        st_q.done  <= 1'b0;
      end else if (go) begin
        st_q <= st_d;
      end else begin
        st_q <= st_q;
      end

      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (go) begin
        in_valid_q <= 1'b0;
      end

      if (go && step_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= table_byte_i;
      in_last_q <= table_last_i;
    end
    if (go && step_emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = res_q.found;
  assign line_start_o   = res_q.line_start;
  assign line_end_o     = res_q.line_end;
  assign column_start_o = res_q.column_start;
  assign column_end_o   = res_q.column_end;

  // a table that already gave its answer yields nothing more
  `CLTD_ASSERT_NOW(a_no_emit_when_done, clk_i, rst_ni, in_valid_q && st_q.done,
    !step_emit, "result from a swallowed byte")
  // only the compact layout can report a miss
  `CLTD_ASSERT_NOW(a_miss_compact_only, clk_i, rst_ni, go && step_emit && !res_d.found,
    cfg_q.fmt == FMT_COMPACT, "miss reported outside compact format")
  // a held byte is never dropped while the output is blocked
  `CLTD_ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_valid_q && !go,
    in_valid_q, "held table byte lost")
  // the last byte of a table always re-arms the parser
  `CLTD_ASSERT_NEXT(a_last_rearms, clk_i, rst_ni, go && in_last_q,
    st_q.phase == PH_START && !st_q.done, "parser not re-armed after last byte")

endmodule

`default_nettype wire
